// ----- rtl/core/pbri_pkg.sv -----
// Shared types and constants of the PCG32 bounded random integer unit.
`timescale 1ns / 1ps

package pbri_pkg;

  // LCG multiplier and register reset values
  localparam logic [63:0] LCG_MULT   = 64'd6364136223846793005;
  localparam logic [63:0] SEED_RESET = 64'h853c49e6748fea9b;
  localparam logic [63:0] INC_RESET  = 64'hda3e39cb94b95bdb;

  // Configuration register indexes
  localparam logic REG_SEED      = 1'b0;
  localparam logic REG_INCREMENT = 1'b1;

  // Request actions
  localparam logic ACT_INTEGER = 1'b0;
  localparam logic ACT_BOOLEAN = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LIMIT,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_REDUCE,
    ST_FINISH
  } pbri_state_t;

  // How the result of the current request is formed
  typedef enum logic [1:0] {
    KIND_BOOL,
    KIND_EQUAL,
    KIND_FULL,
    KIND_BOUNDED
  } pbri_kind_t;

endpackage

// ----- rtl/core/pbri_if.sv -----
// Handshake channel interfaces: request, result and configuration write.
`timescale 1ns / 1ps

interface pbri_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  modport source (output valid, action, range_low, range_high, input ready);
  modport sink   (input valid, action, range_low, range_high, output ready);
endinterface

interface pbri_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

interface pbri_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/pcg32_bounded_random_int_unit.sv -----
// PCG32 (XSH-RR) generator with bounded integer and boolean draws.
`timescale 1ns / 1ps
//
// Channel  Dir  Fields                                Handshake
// req      in   action, range_low, range_high         valid/ready
// rsp      out  random_value                          valid/ready
// cfg      in   index (0 seed, 1 increment), data     valid/ready, ready always high
//
// Equal bounds skip the draw, the full span and boolean draws skip both
// remainders, and a rejected bounded draw is drawn again. Each draw runs on one
// 32x32 multiplier (three partial products and the increment add); each of the
// two remainders is formed by one-bit restoring divide steps.
// rst (synchronous) loads the reset seed and increment and empties the result
// register. A new request is taken only in idle; a waiting result holds the
// sequencer in its final state until the result register is free.

module pcg32_bounded_random_int_unit (
  input  logic       clk,
  input  logic       rst,
  pbri_req_if.sink   req,
  pbri_rsp_if.source rsp,
  pbri_cfg_if.sink   cfg
);

  import pbri_pkg::*;

  pbri_state_t state, state_next;
  pbri_kind_t  kind;

  logic [63:0] gen;
  logic [63:0] inc;
  logic [31:0] val_a, val_b;
  logic        act;
  logic [31:0] lo;
  logic [31:0] span;
  logic [31:0] limit;
  logic [31:0] draw;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic        out_valid;
  logic [31:0] out_value;

  // control decoded from state
  logic div_run, div_last, out_load, reject;

  // bound ordering
  logic        swap;
  logic [31:0] lo_s, hi_s, diff;

  // shared datapath units
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] shifted, trial;
  logic [31:0] rem_step;
  logic [31:0] xsh, perm;
  logic [63:0] rot2;
  logic [31:0] result;

  // order the bounds
  always_comb begin
    swap = $signed(val_a) > $signed(val_b);
    lo_s = swap ? val_b : val_a;
    hi_s = swap ? val_a : val_b;
    diff = hi_s - lo_s;
  end

  // shared 32x32 multiplier, operands picked by step
  assign mul_a = (state == ST_MUL2) ? gen[63:32] : gen[31:0];
  assign mul_b = (state == ST_MUL1) ? LCG_MULT[63:32] : LCG_MULT[31:0];
  assign mul_p = mul_a * mul_b;

  // one restoring divide step
  always_comb begin
    shifted  = {rem, quo[31]};
    trial    = shifted - {1'b0, span};
    rem_step = trial[32] ? shifted[31:0] : trial[31:0];
  end

  // XSH-RR output permutation of the current state
  always_comb begin
    xsh  = gen[58:27] ^ {13'b0, gen[63:45]};
    rot2 = {xsh, xsh} >> gen[63:59];
    perm = rot2[31:0];
  end

  // result formation
  always_comb begin
    unique case (kind)
      KIND_BOOL:    result = {31'b0, draw[0]};
      KIND_EQUAL:   result = lo;
      KIND_FULL:    result = lo + draw;
      KIND_BOUNDED: result = lo + rem;
      default:      result = lo;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
    cfg.ready = 1'b1;
    div_run   = (state == ST_LIMIT) || (state == ST_REDUCE);
    div_last  = div_run && (cnt == 5'd31);
    out_load  = (state == ST_FINISH) && (!out_valid || rsp.ready);
    reject    = draw < limit;
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (req.action == ACT_BOOLEAN) ? ST_MUL0 : ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (diff == 32'd0) begin
          state_next = ST_FINISH;
        end else if (diff == 32'hFFFF_FFFF) begin
          state_next = ST_MUL0;
        end else begin
          state_next = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (div_last) state_next = ST_MUL0;
      end
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: begin
        if (kind != KIND_BOUNDED) begin
          state_next = ST_FINISH;
        end else if (reject) begin
          state_next = ST_MUL0;
        end else begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (div_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state, generator state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gen       <= SEED_RESET;
      inc       <= {INC_RESET[63:1], 1'b1};
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MUL3) begin
        gen <= acc + {prod[31:0], 32'b0};
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_SEED:      gen <= cfg.data;
          REG_INCREMENT: inc <= {cfg.data[63:1], 1'b1};
          default:       ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          act   <= req.action;
          val_a <= req.range_low;
          val_b <= req.range_high;
          kind  <= (req.action == ACT_BOOLEAN) ? KIND_BOOL : KIND_BOUNDED;
        end
      end
      ST_SETUP: begin
        lo   <= lo_s;
        span <= diff + 32'd1;
        quo  <= ~diff;          // dividend 2^32 - span
        rem  <= 32'd0;
        cnt  <= 5'd0;
        if (diff == 32'd0) begin
          kind <= KIND_EQUAL;
        end else if (diff == 32'hFFFF_FFFF) begin
          kind <= KIND_FULL;
        end else begin
          kind <= KIND_BOUNDED;
        end
      end
      ST_LIMIT, ST_REDUCE: begin
        rem <= rem_step;
        quo <= {quo[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (state == ST_LIMIT && div_last) limit <= rem_step;
      end
      ST_MUL0: begin
        prod <= mul_p;
        draw <= perm;
      end
      ST_MUL1: begin
        acc  <= prod + inc;
        prod <= mul_p;
      end
      ST_MUL2: begin
        acc  <= acc + {prod[31:0], 32'b0};
        prod <= mul_p;
      end
      ST_MUL3: begin
        quo <= draw;
        rem <= 32'd0;
        cnt <= 5'd0;
      end
      ST_FINISH: begin
        if (out_load) out_value <= (act == ACT_BOOLEAN) ? {31'b0, draw[0]} : result;
      end
      default: ;
    endcase
  end

  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_value;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the PCG32 bounded random integer unit: predicted draws vs. results.
`timescale 1ns / 1ps

module testbench;
  import pbri_pkg::*;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_PER_PHASE = 188;
  localparam int unsigned PHASE_COUNT = 6;
  localparam int unsigned LONG_HOLD_AT = 500;
  localparam int unsigned LONG_HOLD_CYCLES = 2500;

  typedef struct packed {
    logic               action;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } draw_req_t;

  logic clk;
  logic rst;

  pbri_req_if req_ch ();
  pbri_rsp_if rsp_ch ();
  pbri_cfg_if cfg_ch ();

  pcg32_bounded_random_int_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Generator model: configuration and running state
  logic [63:0] seed_reg;
  logic [63:0] gen_increment;
  logic [63:0] gen_state;

  draw_req_t          pending_requests[$];
  logic signed [31:0] expected_values[$];

  bit          tx_idle;
  bit          rx_idle;
  int unsigned failures;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;
  draw_req_t   next_item;
  draw_req_t   taken_item;
  logic signed [31:0] want;

  // Clock: 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // One LCG step; returns the XSH-RR permutation of the old state
  function automatic logic [31:0] pcg_draw();
    logic [63:0] old;
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] doubled;
    old = gen_state;
    gen_state = old * LCG_MULT + gen_increment;
    mixed = 32'(((old >> 18) ^ old) >> 27);
    rot = old[63:59];
    doubled = {mixed, mixed} >> rot;
    return doubled[31:0];
  endfunction

  // Expected random_value for one accepted request; advances the model state
  function automatic logic signed [31:0] draw_value_for(input draw_req_t r);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] swap;
    logic [31:0] span;
    logic [31:0] limit;
    logic [31:0] draw;
    if (r.action == ACT_BOOLEAN) begin
      draw = pcg_draw();
      return {31'd0, draw[0]};
    end
    lo = r.range_low;
    hi = r.range_high;
    if ($signed(lo) > $signed(hi)) begin
      swap = lo;
      lo = hi;
      hi = swap;
    end
    if (lo == hi) return lo;
    span = hi - lo + 32'd1;
    // span wrapped to zero: all 2^32 values, raw draw added
    if (span == 32'd0) return lo + pcg_draw();
    limit = (32'd0 - span) % span;
    do begin
      draw = pcg_draw();
    end while (draw < limit);
    return lo + draw % span;
  endfunction

  // Idle stretch length: mostly short, sometimes long
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 4);
    return $urandom_range(16, 60);
  endfunction

  function automatic draw_req_t random_request();
    draw_req_t   r;
    int unsigned pick;
    r.action = ($urandom_range(0, 3) == 0) ? ACT_BOOLEAN : ACT_INTEGER;
    r.range_low = $urandom;
    r.range_high = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // narrow span around a random base (may wrap into a reversed pair)
      r.range_high = r.range_low + 32'($urandom_range(0, 40)) - 32'd20;
    end else if (pick < 45) begin
      // span just over 2^31: about half the draws get rejected
      r.range_low = INT_MIN + 32'($urandom_range(0, 1 << 20));
      r.range_high = r.range_low + 32'h8000_0000 + 32'($urandom_range(0, 15));
      if ($urandom_range(0, 1) == 1) begin
        r.range_low = r.range_high;
        r.range_high = INT_MIN + 32'($urandom_range(0, 1 << 20));
        r.range_high = r.range_low - 32'h8000_0000 - 32'($urandom_range(0, 15));
      end
    end else if (pick < 52) begin
      r.range_high = r.range_low;
    end else if (pick < 56) begin
      r.range_low = ($urandom_range(0, 1) == 1) ? INT_MIN : INT_MAX;
      r.range_high = (r.range_low == INT_MIN) ? INT_MAX : INT_MIN;
    end
    return r;
  endfunction

  function automatic void push_request(input logic act, input logic signed [31:0] lo,
                                       input logic signed [31:0] hi);
    draw_req_t r;
    r.action = act;
    r.range_low = lo;
    r.range_high = hi;
    pending_requests.push_back(r);
  endfunction

  // Register write; the model follows at the accepting edge
  task automatic write_register(input logic idx, input logic [63:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_SEED) begin
      seed_reg = value;
      gen_state = value;
    end else begin
      gen_increment = value | 64'd1;
    end
  endtask

  // Wait until every request is taken and answered, then let the unit settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || expected_values.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        taken_item.action = req_ch.action;
        taken_item.range_low = req_ch.range_low;
        taken_item.range_high = req_ch.range_high;
        expected_values.push_back(draw_value_for(taken_item));
      end
      if (gap_left != 0) begin
        req_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
        next_item = pending_requests.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.action <= next_item.action;
        req_ch.range_low <= next_item.range_low;
        req_ch.range_high <= next_item.range_high;
        gap_left <= (tx_idle && $urandom_range(0, 99) < 45) ? idle_length() : 0;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen = results_seen + 1;
        if (expected_values.size() == 0) begin
          $error("random_value: no request outstanding, got %0d", rsp_ch.random_value);
          failures = failures + 1;
        end else begin
          want = expected_values.pop_front();
          if (rsp_ch.random_value !== want) begin
            $error("random_value mismatch: expected %0d, got %0d", want, rsp_ch.random_value);
            failures = failures + 1;
          end
        end
      end
      // one long hold mid-run while the driver keeps offering requests
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= LONG_HOLD_AT) begin
        rsp_ch.ready <= 1'b0;
        hold_left <= LONG_HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (rx_idle && $urandom_range(0, 99) < 30) begin
        rsp_ch.ready <= 1'b0;
        stall_left <= idle_length() - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_INTEGER;
    req_ch.range_low = '0;
    req_ch.range_high = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SEED;
    cfg_ch.data = '0;
    seed_reg = SEED_RESET;
    gen_increment = INC_RESET | 64'd1;
    gen_state = SEED_RESET;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    failures = 0;
    results_seen = 0;
    cycle_count = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed requests on the reset seed and increment
    push_request(ACT_BOOLEAN, 32'sd0, 32'sd0);
    push_request(ACT_BOOLEAN, INT_MIN, INT_MAX);
    push_request(ACT_BOOLEAN, -32'sd1, -32'sd1);
    push_request(ACT_INTEGER, INT_MIN, INT_MAX);      // full span
    push_request(ACT_INTEGER, INT_MAX, INT_MIN);      // full span, reversed
    push_request(ACT_INTEGER, 32'sd7, 32'sd7);        // equal bounds
    push_request(ACT_INTEGER, INT_MIN, INT_MIN);
    push_request(ACT_INTEGER, INT_MAX, INT_MAX);
    push_request(ACT_INTEGER, 32'sd0, 32'sd1);
    push_request(ACT_INTEGER, 32'sd1, 32'sd0);        // reversed
    push_request(ACT_INTEGER, -32'sd1, 32'sd0);
    push_request(ACT_INTEGER, 32'sd100, -32'sd100);   // reversed across zero
    push_request(ACT_INTEGER, INT_MIN, INT_MIN + 32'sd1);
    push_request(ACT_INTEGER, INT_MAX - 32'sd1, INT_MAX);
    push_request(ACT_INTEGER, -32'sd1, INT_MAX);      // span 2^31+1, heavy rejection
    push_request(ACT_INTEGER, -32'sd1, INT_MAX);
    push_request(ACT_INTEGER, INT_MAX, -32'sd1);
    push_request(ACT_INTEGER, INT_MIN, 32'sd0);
    push_request(ACT_INTEGER, INT_MIN, -32'sd1);      // span 2^31, nothing rejected
    push_request(ACT_INTEGER, 32'sd0, 32'sd2);
    push_request(ACT_INTEGER, 32'sd1000, 32'sd1000000);
    push_request(ACT_INTEGER, -32'sd5, -32'sd9);
    wait_idle();

    // Random phases, each on its own seed / increment setting
    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          write_register(REG_SEED, 64'd0);
          write_register(REG_INCREMENT, 64'd0);
        end
        1: begin
          write_register(REG_SEED, '1);
          write_register(REG_INCREMENT, '1);
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        2: begin
          write_register(REG_SEED, {$urandom, $urandom});
          write_register(REG_INCREMENT, {$urandom, $urandom});
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        3: begin
          // increment only: the running state carries over
          write_register(REG_INCREMENT, {$urandom, $urandom});
          rx_idle = 1'b0;
        end
        4: begin
          write_register(REG_SEED, {$urandom, $urandom});
          tx_idle = 1'b0;
          rx_idle = 1'b1;
        end
        default: begin
          write_register(REG_INCREMENT, {$urandom, $urandom} & ~64'd1);
          write_register(REG_SEED, {$urandom, $urandom});
          tx_idle = 1'b1;
        end
      endcase
      for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) begin
        pending_requests.push_back(random_request());
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
